// File: sv/prf_pkg.sv
// Shared types, constants and helpers for the page replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package prf_pkg;

    localparam int NUM_FRAMES  = 8;
    localparam int PAGE_BITS   = 16;
    localparam int IDX_W       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
    localparam int RANK_W      = IDX_W;
    localparam int PAGE_PORT_W = 16;
    localparam int TOTAL_W     = 16;
    localparam int FRAMES_CFG_W = 4;
    localparam int CFG_DATA_W  = 4;
    localparam int CFG_INDEX_W = 1;

    localparam logic [RANK_W-1:0]  RANK_MAX  = RANK_W'(NUM_FRAMES - 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic OPC_REFERENCE = 1'b0;
    localparam logic OPC_RESTART   = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_IN_USE = 1'b1;

    localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = FRAMES_CFG_W'(8);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [PAGE_BITS-1:0] page_t;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_SCAN,
        OP_TOUCH,
        OP_IDLE
    } unit_op_t;

    typedef struct packed {
        logic  valid;
        page_t page;
        rank_t rank;
    } frame_t;

    typedef struct packed {
        logic  found;
        idx_t  hit_idx;
        logic  empty_found;
        idx_t  empty_idx;
        rank_t max_rank;
        idx_t  max_idx;
    } scan_status_t;

    typedef struct packed {
        logic  clear;
        logic  rank_we;
        idx_t  rank_idx;
        rank_t rank_val;
        logic  load_we;
        idx_t  load_idx;
        page_t load_page;
    } store_cmd_t;

    function automatic cnt_t active_frames(logic [FRAMES_CFG_W-1:0] fiu);
        cnt_t f;
        if (fiu == '0) begin
            f = CNT_W'(1);
        end else if (int'(fiu) > NUM_FRAMES) begin
            f = CNT_W'(NUM_FRAMES);
        end else begin
            f = CNT_W'(fiu);
        end
        return f;
    endfunction

endpackage
`default_nettype wire

// File: sv/prf_frame_store.sv
// Frame registers: page, valid bit and recency rank per frame, one read index.
`timescale 1ns / 1ps
`default_nettype none
module prf_frame_store (
    input  wire                  clk,
    input  wire                  rst_n,
    input  prf_pkg::store_cmd_t  cmd,
    input  prf_pkg::idx_t        rd_idx,
    output prf_pkg::frame_t      rd_frame
);
    import prf_pkg::*;

    page_t page_reg  [NUM_FRAMES];
    rank_t rank_reg  [NUM_FRAMES];
    logic  valid_reg [NUM_FRAMES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else if (cmd.clear)
        begin
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.rank_we)
            begin
                rank_reg[cmd.rank_idx] <= cmd.rank_val;
            end
            if (cmd.load_we)
            begin
                valid_reg[cmd.load_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && !cmd.clear)
        begin
            page_reg[cmd.load_idx] <= cmd.load_page;
        end
    end

    assign rd_frame.valid = valid_reg[rd_idx];
    assign rd_frame.page  = page_reg[rd_idx];
    assign rd_frame.rank  = rank_reg[rd_idx];

endmodule
`default_nettype wire

// File: sv/prf_scan_unit.sv
// Shared compare unit: hit, empty and oldest-rank search, and rank aging.
`timescale 1ns / 1ps
`default_nettype none
module prf_scan_unit (
    input  wire                    clk,
    input  wire                    rst_n,
    input  prf_pkg::unit_op_t      op,
    input  prf_pkg::idx_t          idx,
    input  prf_pkg::frame_t        frame,
    input  prf_pkg::page_t         page,
    input  prf_pkg::idx_t          target_idx,
    input  wire                    target_was_valid,
    input  prf_pkg::rank_t         target_rank,
    output prf_pkg::scan_status_t  status,
    output logic                   age_we,
    output prf_pkg::rank_t         age_rank
);
    import prf_pkg::*;

    scan_status_t status_reg;
    scan_status_t status_next;

    always_comb
    begin
        status_next = status_reg;
        unique case (op)
            OP_CLEAR:
            begin
                status_next = '0;
            end
            OP_SCAN:
            begin
                if (frame.valid && frame.page == page && !status_reg.found)
                begin
                    status_next.found   = 1'b1;
                    status_next.hit_idx = idx;
                end
                if (!frame.valid && !status_reg.empty_found)
                begin
                    status_next.empty_found = 1'b1;
                    status_next.empty_idx   = idx;
                end
                if (idx == '0 || frame.rank > status_reg.max_rank)
                begin
                    status_next.max_rank = frame.rank;
                    status_next.max_idx  = idx;
                end
            end
            OP_TOUCH, OP_IDLE:
            begin
                status_next = status_reg;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
        end
        else
        begin
            status_reg <= status_next;
        end
    end

    assign status   = status_reg;
    assign age_we   = (op == OP_TOUCH) && (idx != target_idx) && frame.valid
                      && (!target_was_valid || frame.rank < target_rank)
                      && (frame.rank < RANK_MAX);
    assign age_rank = frame.rank + RANK_W'(1);

endmodule
`default_nettype wire

// File: sv/page_replacement_fifo_lru_unit.sv
// Top level: reference sequencer, counters, configuration and result register.
// A page reference is handled in two walks over the F active frames, where
// F is the number of active frames (frames_in_use clamped to 1..8): the single
// compare unit walks the frames once to find a hit, an empty frame and the
// oldest rank, and walks them again to age the ranks, one frame per cycle.
// A restart clears frames and counters. The result sits in an output register,
// so a new beat is taken while the previous result still waits downstream.
`timescale 1ns / 1ps
`default_nettype none
module page_replacement_fifo_lru_unit (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire  [prf_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire  [prf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  wire                                    in_valid,
    output logic                                   in_stall,
    input  wire                                    opcode,
    input  wire  [prf_pkg::PAGE_PORT_W-1:0]        page_number,
    output logic                                   out_valid,
    input  wire                                    out_stall,
    output logic                                   hit,
    output logic                                   evicted_valid,
    output logic [prf_pkg::PAGE_PORT_W-1:0]        evicted_page,
    output logic [prf_pkg::TOTAL_W-1:0]            fault_total,
    output logic [prf_pkg::TOTAL_W-1:0]            hit_total
);
    import prf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_READK,
        S_TOUCH,
        S_COMMIT,
        S_EMIT
    } state_t;

    state_t                  state_reg;
    idx_t                    idx_reg;
    idx_t                    k_reg;
    logic                    was_valid_reg;
    rank_t                   old_rank_reg;
    logic                    hit_flag_reg;
    logic                    ev_valid_reg;
    logic [PAGE_PORT_W-1:0]  ev_page_reg;
    page_t                   page_reg;
    idx_t                    ptr_reg;
    logic [TOTAL_W-1:0]      fault_cnt_reg;
    logic [TOTAL_W-1:0]      hit_cnt_reg;
    logic                    policy_reg;
    logic [FRAMES_CFG_W-1:0] fiu_reg;
    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic                    out_ev_valid_reg;
    logic [PAGE_PORT_W-1:0]  out_ev_page_reg;
    logic [TOTAL_W-1:0]      out_fault_reg;
    logic [TOTAL_W-1:0]      out_hit_total_reg;

    cnt_t          f;
    logic          last;
    logic          in_accept;
    logic          emit_load;
    idx_t          fifo_slot;
    cnt_t          slot_inc;
    idx_t          ptr_next;
    idx_t          k_next;
    idx_t          rd_idx;
    frame_t        rd_frame;
    store_cmd_t    cmd;
    unit_op_t      op;
    scan_status_t  status;
    logic          age_we;
    rank_t         age_rank;

    assign f         = active_frames(fiu_reg);
    assign last      = (CNT_W'(idx_reg) == f - CNT_W'(1));
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);

    assign fifo_slot = (CNT_W'(ptr_reg) >= f) ? '0 : ptr_reg;
    assign slot_inc  = CNT_W'(fifo_slot) + CNT_W'(1);
    assign ptr_next  = (slot_inc >= f) ? '0 : IDX_W'(slot_inc);

    always_comb
    begin
        priority if (status.found)
        begin
            k_next = status.hit_idx;
        end
        else if (policy_reg == POLICY_FIFO)
        begin
            k_next = fifo_slot;
        end
        else if (status.empty_found)
        begin
            k_next = status.empty_idx;
        end
        else
        begin
            k_next = status.max_idx;
        end
    end

    assign rd_idx = (state_reg == S_READK) ? k_reg : idx_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  op = OP_CLEAR;
            S_SCAN:  op = OP_SCAN;
            S_TOUCH: op = OP_TOUCH;
            default: op = OP_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.clear     = in_accept && (opcode == OPC_RESTART);
        cmd.load_idx  = k_reg;
        cmd.load_page = page_reg;
        cmd.load_we   = (state_reg == S_COMMIT) && !hit_flag_reg;
        if (state_reg == S_TOUCH)
        begin
            cmd.rank_we  = age_we;
            cmd.rank_idx = idx_reg;
            cmd.rank_val = age_rank;
        end
        else if (state_reg == S_COMMIT)
        begin
            cmd.rank_we  = 1'b1;
            cmd.rank_idx = k_reg;
            cmd.rank_val = '0;
        end
    end

    prf_frame_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_frame (rd_frame)
    );

    prf_scan_unit u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .idx              (idx_reg),
        .frame            (rd_frame),
        .page             (page_reg),
        .target_idx       (k_reg),
        .target_was_valid (was_valid_reg),
        .target_rank      (old_rank_reg),
        .status           (status),
        .age_we           (age_we),
        .age_rank         (age_rank)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            fiu_reg    <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLICY_MODE:   policy_reg <= cfg_data[0];
                CFG_FRAMES_IN_USE: fiu_reg    <= cfg_data[FRAMES_CFG_W-1:0];
                default:           policy_reg <= policy_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= '0;
            k_reg             <= '0;
            was_valid_reg     <= 1'b0;
            old_rank_reg      <= '0;
            hit_flag_reg      <= 1'b0;
            ev_valid_reg      <= 1'b0;
            ev_page_reg       <= '0;
            page_reg          <= '0;
            ptr_reg           <= '0;
            fault_cnt_reg     <= '0;
            hit_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_hit_reg       <= 1'b0;
            out_ev_valid_reg  <= 1'b0;
            out_ev_page_reg   <= '0;
            out_fault_reg     <= '0;
            out_hit_total_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && !emit_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        if (opcode == OPC_RESTART)
                        begin
                            fault_cnt_reg <= '0;
                            hit_cnt_reg   <= '0;
                            ptr_reg       <= '0;
                            hit_flag_reg  <= 1'b0;
                            ev_valid_reg  <= 1'b0;
                            ev_page_reg   <= '0;
                            state_reg     <= S_EMIT;
                        end
                        else
                        begin
                            page_reg  <= PAGE_BITS'(page_number);
                            idx_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last)
                    begin
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_PICK:
                begin
                    k_reg        <= k_next;
                    hit_flag_reg <= status.found;
                    if (!status.found && policy_reg == POLICY_FIFO)
                    begin
                        ptr_reg <= ptr_next;
                    end
                    state_reg <= S_READK;
                end
                S_READK:
                begin
                    was_valid_reg <= rd_frame.valid;
                    old_rank_reg  <= rd_frame.rank;
                    ev_valid_reg  <= !hit_flag_reg && rd_frame.valid;
                    ev_page_reg   <= (!hit_flag_reg && rd_frame.valid)
                                     ? PAGE_PORT_W'(rd_frame.page) : '0;
                    idx_reg       <= '0;
                    state_reg     <= S_TOUCH;
                end
                S_TOUCH:
                begin
                    if (last)
                    begin
                        state_reg <= S_COMMIT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                S_COMMIT:
                begin
                    if (hit_flag_reg)
                    begin
                        if (hit_cnt_reg != TOTAL_MAX)
                        begin
                            hit_cnt_reg <= hit_cnt_reg + TOTAL_W'(1);
                        end
                    end
                    else if (fault_cnt_reg != TOTAL_MAX)
                    begin
                        fault_cnt_reg <= fault_cnt_reg + TOTAL_W'(1);
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_load)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_hit_reg       <= hit_flag_reg;
                        out_ev_valid_reg  <= ev_valid_reg;
                        out_ev_page_reg   <= ev_page_reg;
                        out_fault_reg     <= fault_cnt_reg;
                        out_hit_total_reg <= hit_cnt_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign fault_total   = out_fault_reg;
    assign hit_total     = out_hit_total_reg;

endmodule
`default_nettype wire
